// ----- rtl/core/jhg_pkg.sv -----
package jhg_pkg;

    localparam int VALUE_BITS = 24;
    localparam int SUM_BITS   = VALUE_BITS + 2;
    localparam int DIV_STEPS  = VALUE_BITS;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef enum logic [2:0] {
        REG_GRID_SIZE  = 3'd0,
        REG_MAX_ITER   = 3'd1,
        REG_TOLERANCE  = 3'd2,
        REG_CHECK_INT  = 3'd3,
        REG_CORNER_TL  = 3'd4,
        REG_CORNER_TR  = 3'd5,
        REG_CORNER_BL  = 3'd6,
        REG_CORNER_BR  = 3'd7
    } reg_index_t;

    typedef enum logic {
        OP_RUN  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_EDGE,
        ST_SWEEP,
        ST_DECIDE,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_TOP    = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_RIGHT  = 2'd3
    } edge_sel_t;

endpackage

// ----- rtl/core/jhg_ifc.sv -----
interface jhg_cmd_if;
    import jhg_pkg::*;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [6:0] row;
    logic [6:0] column;

    modport source (output valid, operation, row, column, input ready);
    modport sink   (input valid, operation, row, column, output ready);
endinterface

interface jhg_res_if;
    import jhg_pkg::*;
    logic        valid;
    logic        ready;
    logic [23:0] cell_value;
    logic [23:0] sweeps_done;
    logic [23:0] final_change;
    logic        converged;

    modport source (output valid, cell_value, sweeps_done, final_change, converged,
                    input ready);
    modport sink   (input valid, cell_value, sweeps_done, final_change, converged,
                    output ready);
endinterface

// ----- rtl/core/jacobi_heat_grid_solver_top.sv -----
// channel | dir | handshake   | payload
// cmd     | in  | valid/ready | operation, row, column
// res     | out | valid/ready | cell_value, sweeps_done, final_change, converged
// apb     | in  | psel/penable| 8 registers at 4*i, pready tied high
//
// a read request passes through a wait state and a finish state; a run clears all n*n
// cells, then per edge runs the restoring divider and walks the n edge cells, then sweeps
// the interior cells through the single read port of the grid memory (5 reads per cell)
// cmd.ready is high only in idle; a finished result waits in its own state
// until the output register is free, so a stalled res side holds the block
// rst_n clears control state only; grid memories hold garbage until a run
module jacobi_heat_grid_solver_top #(
    parameter int MAX_GRID = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    jhg_cmd_if.sink      cmd,
    jhg_res_if.source    res
);
    import jhg_pkg::*;

    localparam int CELLS = MAX_GRID * MAX_GRID;
    localparam int AW    = $clog2(CELLS);

    // configuration
    logic [7:0]  gs_reg;
    logic [23:0] lim_reg, tol_reg;
    logic [15:0] ci_reg;
    value_t      tl_reg, tr_reg, bl_reg, br_reg;

    state_t      state_reg, state_next;
    logic [7:0]  n_reg, n_next, side_reg, side_next;
    logic [7:0]  r_reg, r_next, c_reg, c_next;
    logic [2:0]  ph_reg, ph_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    value_t      maxd_reg, maxd_next;
    logic [23:0] k_reg, k_next;
    value_t      last_reg, last_next;
    logic        conv_reg, conv_next;
    logic [15:0] cc_reg, cc_next;
    logic        ob_reg, ob_next, nb_reg, nb_next;
    logic [1:0]  edge_reg, edge_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    value_t      dv_reg, dv_next, q_reg, q_next;
    logic [7:0]  rm_reg, rm_next, dr_reg, dr_next;
    value_t      dq_reg, dq_next;
    value_t      cell_reg, cell_next;
    logic        ov_reg, ov_next;
    value_t      ocell_reg, ocell_next, och_reg, och_next;
    logic [23:0] osw_reg, osw_next;
    logic        ocv_reg, ocv_next;
    logic        rsel_reg;

    // memories
    value_t      mem_a [CELLS];
    value_t      mem_b [CELLS];
    value_t      rd_a_reg, rd_b_reg, rdata;
    logic [7:0]  ar, ac;
    logic [AW-1:0] addr;
    logic        we_a, we_b, rsel;
    value_t      wdata;

    // comb helpers
    logic        wr_cfg, cmd_acc, out_free;
    logic [7:0]  n_clamp, d_val;
    value_t      ea, eb, ediff, evalue;
    logic        e_up;
    logic [8:0]  div_t, rm_sum;
    logic [15:0] ci_eff, cc_inc;
    logic [24:0] next_k;
    logic [23:0] k_inc;
    value_t      v_avg, v_diff;
    logic        last_cell, is_mult;

    assign pready   = 1'b1;
    assign wr_cfg   = psel && penable && pwrite;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc  = cmd.valid && cmd.ready;
    assign out_free = !ov_reg || res.ready;

    assign res.valid        = ov_reg;
    assign res.cell_value   = ocell_reg;
    assign res.sweeps_done  = osw_reg;
    assign res.final_change = och_reg;
    assign res.converged    = ocv_reg;

    always_comb
    begin
        case (reg_index_t'(paddr[4:2]))
            REG_GRID_SIZE: prdata = {24'd0, gs_reg};
            REG_MAX_ITER:  prdata = {8'd0, lim_reg};
            REG_TOLERANCE: prdata = {8'd0, tol_reg};
            REG_CHECK_INT: prdata = {16'd0, ci_reg};
            REG_CORNER_TL: prdata = {8'd0, tl_reg};
            REG_CORNER_TR: prdata = {8'd0, tr_reg};
            REG_CORNER_BL: prdata = {8'd0, bl_reg};
            REG_CORNER_BR: prdata = {8'd0, br_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg  <= 8'd128;
            lim_reg <= 24'd1000000;
            tol_reg <= 24'd66;
            ci_reg  <= 16'd1000;
            tl_reg  <= 24'd655360;
            tr_reg  <= 24'd1310720;
            bl_reg  <= 24'd1310720;
            br_reg  <= 24'd1966080;
        end
        else if (wr_cfg)
        begin
            case (reg_index_t'(paddr[4:2]))
                REG_GRID_SIZE: gs_reg  <= pwdata[7:0];
                REG_MAX_ITER:  lim_reg <= pwdata[23:0];
                REG_TOLERANCE: tol_reg <= pwdata[23:0];
                REG_CHECK_INT: ci_reg  <= pwdata[15:0];
                REG_CORNER_TL: tl_reg  <= pwdata[23:0];
                REG_CORNER_TR: tr_reg  <= pwdata[23:0];
                REG_CORNER_BL: bl_reg  <= pwdata[23:0];
                REG_CORNER_BR: br_reg  <= pwdata[23:0];
                default:       ;
            endcase
        end
    end

    // clamp of the side length
    always_comb
    begin
        if (gs_reg < 8'd3)
            n_clamp = 8'd3;
        else if (int'(gs_reg) > MAX_GRID)
            n_clamp = 8'(MAX_GRID);
        else
            n_clamp = gs_reg;
    end

    assign d_val  = n_reg - 8'd1;
    assign ci_eff = (ci_reg == 16'd0) ? 16'd1 : ci_reg;

    // edge endpoints
    always_comb
    begin
        case (edge_sel_t'(edge_reg))
            EDGE_LEFT:   begin ea = tl_reg; eb = bl_reg; end
            EDGE_TOP:    begin ea = tl_reg; eb = tr_reg; end
            EDGE_BOTTOM: begin ea = bl_reg; eb = br_reg; end
            EDGE_RIGHT:  begin ea = tr_reg; eb = br_reg; end
            default:     begin ea = tl_reg; eb = bl_reg; end
        endcase
    end

    assign e_up   = (eb >= ea);
    assign ediff  = e_up ? (eb - ea) : (ea - eb);
    // falling edge rounds the step up so the value is floored
    assign evalue = e_up ? (ea + q_reg) : (ea - q_reg - value_t'(rm_reg != 8'd0));
    assign div_t  = {rm_reg, dv_reg[VALUE_BITS-1]};
    assign rm_sum = {1'b0, rm_reg} + {1'b0, dr_reg};

    assign v_avg  = sum_reg[SUM_BITS-1:2];
    assign v_diff = (v_avg >= rdata) ? (v_avg - rdata) : (rdata - v_avg);
    assign last_cell = (r_reg == n_reg - 8'd2) && (c_reg == n_reg - 8'd2);

    assign k_inc   = k_reg + 24'd1;
    assign is_mult = (cc_reg + 16'd1 == ci_eff);
    assign cc_inc  = is_mult ? 16'd0 : cc_reg + 16'd1;
    assign next_k  = {1'b0, k_inc} + {9'd0, ci_eff - cc_inc};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                    state_next = (cmd.operation == OP_READ) ? ST_RD_WAIT : ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (r_reg == d_val && c_reg == d_val)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                    state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (r_reg == d_val)
                begin
                    if (edge_reg != 2'd3)
                        state_next = ST_DIV;
                    else if (lim_reg == 24'd0)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (ph_reg == 3'd5 && last_cell)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (is_mult)
                    state_next = (maxd_reg <= tol_reg || k_inc >= lim_reg)
                                 ? ST_FINISH : ST_SWEEP;
                else if (maxd_reg == '0 || k_inc >= lim_reg)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SWEEP;
            end
            ST_RD_WAIT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        n_next    = n_reg;
        side_next = side_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        ph_next   = ph_reg;
        sum_next  = sum_reg;
        maxd_next = maxd_reg;
        k_next    = k_reg;
        last_next = last_reg;
        conv_next = conv_reg;
        cc_next   = cc_reg;
        ob_next   = ob_reg;
        nb_next   = nb_reg;
        edge_next = edge_reg;
        cnt_next  = cnt_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        rm_next   = rm_reg;
        dq_next   = dq_reg;
        dr_next   = dr_reg;
        cell_next = cell_reg;
        ov_next   = ov_reg;
        ocell_next = ocell_reg;
        osw_next  = osw_reg;
        och_next  = och_reg;
        ocv_next  = ocv_reg;
        ar        = r_reg;
        ac        = c_reg;
        rsel      = ob_reg;
        we_a      = 1'b0;
        we_b      = 1'b0;
        wdata     = '0;

        if (ov_reg && res.ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                ar   = {1'b0, cmd.row};
                ac   = {1'b0, cmd.column};
                rsel = nb_reg;
                if (cmd_acc)
                begin
                    if (cmd.operation == OP_READ)
                    begin
                        r_next = {1'b0, cmd.row};
                        c_next = {1'b0, cmd.column};
                    end
                    else
                    begin
                        n_next    = n_clamp;
                        side_next = n_clamp;
                        r_next    = '0;
                        c_next    = '0;
                        k_next    = '0;
                        last_next = '0;
                        conv_next = 1'b0;
                        cc_next   = '0;
                        ob_next   = 1'b0;
                        nb_next   = 1'b0;
                        edge_next = 2'd0;
                        cnt_next  = '0;
                        cell_next = '0;
                    end
                end
            end
            ST_CLEAR:
            begin
                we_a = 1'b1;
                we_b = 1'b1;
                if (c_reg == d_val)
                begin
                    c_next = '0;
                    r_next = r_reg + 8'd1;
                end
                else
                    c_next = c_reg + 8'd1;
                if (r_reg == d_val && c_reg == d_val)
                begin
                    cnt_next = '0;
                    dv_next  = ediff;
                    rm_next  = '0;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (div_t >= {1'b0, d_val})
                begin
                    rm_next = 8'(div_t - {1'b0, d_val});
                    dv_next = {dv_reg[VALUE_BITS-2:0], 1'b1};
                end
                else
                begin
                    rm_next = div_t[7:0];
                    dv_next = {dv_reg[VALUE_BITS-2:0], 1'b0};
                end
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                begin
                    dq_next = dv_next;
                    dr_next = rm_next;
                    q_next  = '0;
                    rm_next = '0;
                    r_next  = '0;
                end
            end
            ST_EDGE:
            begin
                we_a  = 1'b1;
                we_b  = 1'b1;
                wdata = evalue;
                case (edge_sel_t'(edge_reg))
                    EDGE_LEFT:   begin ar = r_reg; ac = '0;    end
                    EDGE_TOP:    begin ar = '0;    ac = r_reg; end
                    EDGE_BOTTOM: begin ar = d_val; ac = r_reg; end
                    EDGE_RIGHT:  begin ar = r_reg; ac = d_val; end
                    default:     begin ar = r_reg; ac = '0;    end
                endcase
                r_next = r_reg + 8'd1;
                if (rm_sum >= {1'b0, d_val})
                begin
                    rm_next = 8'(rm_sum - {1'b0, d_val});
                    q_next  = q_reg + dq_reg + value_t'(1);
                end
                else
                begin
                    rm_next = rm_sum[7:0];
                    q_next  = q_reg + dq_reg;
                end
                if (r_reg == d_val)
                begin
                    edge_next = edge_reg + 2'd1;
                    cnt_next  = '0;
                    rm_next   = '0;
                    r_next    = 8'd1;
                    c_next    = 8'd1;
                    ph_next   = '0;
                    maxd_next = '0;
                    case (edge_sel_t'(edge_next))
                        EDGE_LEFT:   dv_next = (bl_reg >= tl_reg) ? bl_reg - tl_reg
                                                                  : tl_reg - bl_reg;
                        EDGE_TOP:    dv_next = (tr_reg >= tl_reg) ? tr_reg - tl_reg
                                                                  : tl_reg - tr_reg;
                        EDGE_BOTTOM: dv_next = (br_reg >= bl_reg) ? br_reg - bl_reg
                                                                  : bl_reg - br_reg;
                        EDGE_RIGHT:  dv_next = (br_reg >= tr_reg) ? br_reg - tr_reg
                                                                  : tr_reg - br_reg;
                        default:     dv_next = '0;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                rsel = ob_reg;
                case (ph_reg)
                    3'd0:    begin ar = r_reg - 8'd1; ac = c_reg; end
                    3'd1:    begin ar = r_reg + 8'd1; ac = c_reg; end
                    3'd2:    begin ar = r_reg; ac = c_reg - 8'd1; end
                    3'd3:    begin ar = r_reg; ac = c_reg + 8'd1; end
                    default: begin ar = r_reg; ac = c_reg; end
                endcase
                // read data comes back in the cycle after its address
                if (ph_reg == 3'd1)
                    sum_next = SUM_BITS'(rdata);
                else if (ph_reg != 3'd0 && ph_reg != 3'd5)
                    sum_next = sum_reg + SUM_BITS'(rdata);
                if (ph_reg == 3'd5)
                begin
                    wdata = v_avg;
                    we_a  = ob_reg;
                    we_b  = !ob_reg;
                    if (v_diff > maxd_reg)
                        maxd_next = v_diff;
                    ph_next = '0;
                    if (c_reg == n_reg - 8'd2)
                    begin
                        c_next = 8'd1;
                        r_next = r_reg + 8'd1;
                    end
                    else
                        c_next = c_reg + 8'd1;
                    if (last_cell)
                        nb_next = !ob_reg;
                end
                else
                    ph_next = ph_reg + 3'd1;
            end
            ST_DECIDE:
            begin
                k_next  = k_inc;
                cc_next = cc_inc;
                r_next  = 8'd1;
                c_next  = 8'd1;
                ph_next = '0;
                maxd_next = '0;
                if (is_mult)
                begin
                    last_next = maxd_reg;
                    if (maxd_reg <= tol_reg)
                        conv_next = 1'b1;
                    else
                        ob_next = !ob_reg;
                end
                else if (maxd_reg == '0)
                begin
                    // fixed point: jump to the next check or to the limit
                    if (next_k <= {1'b0, lim_reg})
                    begin
                        k_next    = next_k[23:0];
                        last_next = '0;
                        conv_next = 1'b1;
                    end
                    else
                        k_next = lim_reg;
                end
                else
                    ob_next = !ob_reg;
            end
            ST_RD_WAIT:
            begin
                cell_next = (r_reg < side_reg && c_reg < side_reg) ? rdata : '0;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ocell_next = cell_reg;
                    osw_next   = k_reg;
                    och_next   = last_reg;
                    ocv_next   = conv_reg;
                end
            end
            default: ;
        endcase
    end

    assign addr  = AW'(AW'(ar) * AW'(MAX_GRID) + AW'(ac));
    assign rdata = rsel_reg ? rd_b_reg : rd_a_reg;

    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a[addr] <= wdata;
        rd_a_reg <= mem_a[addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            mem_b[addr] <= wdata;
        rd_b_reg <= mem_b[addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        c_reg     <= c_next;
        sum_reg   <= sum_next;
        maxd_reg  <= maxd_next;
        dv_reg    <= dv_next;
        q_reg     <= q_next;
        rm_reg    <= rm_next;
        dq_reg    <= dq_next;
        dr_reg    <= dr_next;
        cell_reg  <= cell_next;
        ocell_reg <= ocell_next;
        rsel_reg  <= rsel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= 8'd3;
            side_reg  <= '0;
            ph_reg    <= '0;
            k_reg     <= '0;
            last_reg  <= '0;
            conv_reg  <= 1'b0;
            cc_reg    <= '0;
            ob_reg    <= 1'b0;
            nb_reg    <= 1'b0;
            edge_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            osw_reg   <= '0;
            och_reg   <= '0;
            ocv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            side_reg  <= side_next;
            ph_reg    <= ph_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
            conv_reg  <= conv_next;
            cc_reg    <= cc_next;
            ob_reg    <= ob_next;
            nb_reg    <= nb_next;
            edge_reg  <= edge_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            osw_reg   <= osw_next;
            och_reg   <= och_next;
            ocv_reg   <= ocv_next;
        end
    end

endmodule
